>>> design/sfe_pkg.sv
package sfe_pkg;

    localparam int IN_DATA_WIDTH  = 32;
    localparam int ROOT_WIDTH     = 16;
    localparam int FREE_WIDTH     = 31;
    localparam int OUT_DATA_WIDTH = 48;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_CHECK,
        S_DIVIDE,
        S_EVAL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic div_start;
        logic div_step;
        logic take_factor;
        logic next_cand;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fits;
        logic div_last;
        logic exact;
        logic out_free;
    } sts_t;

endpackage

>>> design/sfe_ctrl.sv
module sfe_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  sfe_pkg::sts_t sts,
    output sfe_pkg::cmd_t cmd
);

    sfe_pkg::state_t state_reg;
    sfe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfe_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfe_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sfe_pkg::S_SQUARE;
                end
            end
            sfe_pkg::S_SQUARE:
            begin
                state_next = sfe_pkg::S_CHECK;
            end
            sfe_pkg::S_CHECK:
            begin
                state_next = sts.fits ? sfe_pkg::S_DIVIDE : sfe_pkg::S_FINISH;
            end
            sfe_pkg::S_DIVIDE:
            begin
                if (sts.div_last)
                begin
                    state_next = sfe_pkg::S_EVAL;
                end
            end
            sfe_pkg::S_EVAL:
            begin
                state_next = sfe_pkg::S_SQUARE;
            end
            sfe_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = sfe_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sfe_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            sfe_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            sfe_pkg::S_SQUARE:
            begin
                cmd.square = 1'b1;
            end
            sfe_pkg::S_CHECK:
            begin
                cmd.div_start = sts.fits;
            end
            sfe_pkg::S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            sfe_pkg::S_EVAL:
            begin
                cmd.take_factor = sts.exact;
                cmd.next_cand   = !sts.exact;
            end
            sfe_pkg::S_FINISH:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/sfe_datapath.sv
module sfe_datapath
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [sfe_pkg::IN_DATA_WIDTH-1:0]  in_data,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [sfe_pkg::OUT_DATA_WIDTH-1:0] out_data,
    input  sfe_pkg::cmd_t                      cmd,
    output sfe_pkg::sts_t                      sts
);

    localparam int KW  = VALUE_WIDTH / 2 + 1;
    localparam int SW  = 2 * KW;
    localparam int CW  = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic [KW-1:0]          mul_a;
    logic [SW-1:0]          prod;
    logic [SW:0]            shifted;
    logic                   sub_ok;

    logic [VALUE_WIDTH-1:0] m_reg, m_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [KW-1:0]          p_reg, p_next;
    logic [SW-1:0]          sq_reg, sq_next;
    logic [SW-1:0]          rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [sfe_pkg::ROOT_WIDTH-1:0] root_reg, root_next;
    logic [sfe_pkg::FREE_WIDTH-1:0] free_reg, free_next;

    assign raw     = VALUE_WIDTH'(in_data);
    assign mag     = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
    assign mul_a   = cmd.take_factor ? k_reg : p_reg;
    assign prod    = SW'(mul_a) * SW'(p_reg);
    assign shifted = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign sub_ok  = shifted >= {1'b0, sq_reg};

    assign sts.fits     = sq_reg <= SW'(m_reg);
    assign sts.div_last = cnt_reg == '0;
    assign sts.exact    = rem_reg == '0;
    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        m_next         = m_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        root_next      = root_reg;
        free_next      = free_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            m_next = mag;
            k_next = (mag == '0) ? KW'(0) : KW'(1);
            p_next = KW'(2);
        end
        if (cmd.square)
        begin
            sq_next = prod;
        end
        if (cmd.div_start)
        begin
            rem_next  = '0;
            quot_next = m_reg;
            cnt_next  = CW'(VALUE_WIDTH - 1);
        end
        if (cmd.div_step)
        begin
            rem_next  = sub_ok ? SW'(shifted - {1'b0, sq_reg}) : SW'(shifted);
            quot_next = {quot_reg[VALUE_WIDTH-2:0], sub_ok};
            cnt_next  = cnt_reg - 1'b1;
        end
        if (cmd.take_factor)
        begin
            k_next = KW'(prod);
            m_next = quot_reg;
        end
        if (cmd.next_cand)
        begin
            p_next = (p_reg == KW'(2)) ? KW'(3) : p_reg + KW'(2);
        end
        if (cmd.out_load)
        begin
            root_next      = sfe_pkg::ROOT_WIDTH'(k_reg);
            free_next      = sfe_pkg::FREE_WIDTH'(m_reg);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        k_reg    <= k_next;
        p_reg    <= p_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
        root_reg <= root_next;
        free_reg <= free_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {1'b0, free_reg, root_reg};

endmodule

>>> design/square_factor_extractor_top.sv
// Sequence: each candidate is squared and, while its square fits the value, the value is
//   divided by it in the shift-subtract divider, which takes one quotient bit a cycle.
// Intake: the next word is taken only once the result is in the output register, so a
//   waiting result does not stall the intake.
// Reset: rst_n clears the controller state and the output valid flag only.
module square_factor_extractor_top
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sfe_pkg::IN_DATA_WIDTH-1:0]  s_tdata,  // value[31:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sfe_pkg::OUT_DATA_WIDTH-1:0] m_tdata   // root_factor[15:0], square_free_part[46:16]
);

    sfe_pkg::cmd_t cmd;
    sfe_pkg::sts_t sts;

    sfe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfe_datapath
    #(
        .VALUE_WIDTH (VALUE_WIDTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> sim/tb_square_factor_extractor_top.sv
`timescale 1ns / 1ps

module tb_square_factor_extractor_top;

    localparam int unsigned WATCHDOG_LIMIT = 4_000_000;

    typedef struct packed {
        logic [sfe_pkg::ROOT_WIDTH-1:0] root_factor;
        logic [sfe_pkg::FREE_WIDTH-1:0] square_free_part;
    } split_t;

    logic                               clk;
    logic                               rst_n    = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [sfe_pkg::IN_DATA_WIDTH-1:0]  s_tdata  = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [sfe_pkg::OUT_DATA_WIDTH-1:0] m_tdata;

    split_t      expected_splits[$];
    int unsigned fail_count   = 0;
    int unsigned idle_pct     = 0;
    int unsigned rx_gap       = 0;
    int unsigned rx_hold      = 0;
    int unsigned hold_len     = 0;
    bit          hold_request = 1'b0;
    int unsigned quiet_cycles = 0;

    square_factor_extractor_top #(
        .VALUE_WIDTH (32)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic split_t split_square(
        input logic [sfe_pkg::IN_DATA_WIDTH-1:0] value
    );
        split_t                            r;
        logic [sfe_pkg::IN_DATA_WIDTH-1:0] mag;
        longint unsigned                   n;
        longint unsigned                   k;
        longint unsigned                   p;
        mag = value[sfe_pkg::IN_DATA_WIDTH-1] ? (~value + 1'b1) : value;
        n   = mag;
        k   = 1;
        p   = 2;
        if (n == 0)
        begin
            r.root_factor      = '0;
            r.square_free_part = '0;
            return r;
        end
        while (p <= n / p)
        begin
            if (n % (p * p) == 0)
            begin
                k = k * p;
                n = n / (p * p);
            end
            else
            begin
                p = (p == 2) ? 3 : p + 2;
            end
        end
        r.root_factor      = k[sfe_pkg::ROOT_WIDTH-1:0];
        r.square_free_part = n[sfe_pkg::FREE_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic [sfe_pkg::IN_DATA_WIDTH-1:0] signed_value(
        input longint unsigned mag
    );
        logic [sfe_pkg::IN_DATA_WIDTH-1:0] v;
        v = mag[sfe_pkg::IN_DATA_WIDTH-1:0];
        return ($urandom_range(0, 1) == 1) ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [sfe_pkg::IN_DATA_WIDTH-1:0] pick_value();
        int unsigned     pick;
        int unsigned     smooth_primes[6];
        longint unsigned mag;
        longint unsigned k;
        longint unsigned q;
        smooth_primes = '{2, 3, 5, 7, 11, 13};
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            mag = 0;
        end
        else if (pick < 42)
        begin
            mag = $urandom_range(1, 4095);
        end
        else if (pick < 77)
        begin
            k   = $urandom_range(1, 255);
            mag = k * k * $urandom_range(1, 1023);
        end
        else if (pick < 95)
        begin
            mag = 1;
            repeat (40)
            begin
                q = smooth_primes[$urandom_range(0, 5)];
                if (mag * q <= 64'd2147483647)
                    mag = mag * q;
            end
        end
        else
        begin
            mag = $urandom_range(4096, 1 << 20);
        end
        return signed_value(mag);
    endfunction

    task automatic send_value(input logic [sfe_pkg::IN_DATA_WIDTH-1:0] value);
        int unsigned gap;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        expected_splits.push_back(split_square(value));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_splits.size() != 0);
    endtask

    task automatic test_corner_values();
        idle_pct = 30;
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'd2);
        send_value(-32'sd2);
        send_value(32'd4);
        send_value(32'd8);
        send_value(32'd12);
        send_value(32'd36);
        send_value(32'd72);
        send_value(32'd97);
        send_value(32'd147);
        send_value(32'd1575);
        send_value(32'd65536);
        send_value(32'd1334025);
        send_value(32'd1073741824);
        send_value(32'd2147395600);
        send_value(-32'sd2147395600);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(-32'sd18);
    endtask

    task automatic test_output_backpressure();
        idle_pct     = 0;
        hold_len     = 400;
        hold_request = 1'b1;
        repeat (8) send_value(signed_value($urandom_range(0, 63)));
    endtask

    task automatic test_pause_until_drained();
        idle_pct = 20;
        repeat (10) send_value(pick_value());
        drain_results();
        repeat (10) send_value(pick_value());
    endtask

    task automatic test_mixed_random(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                idle_pct = ((i / 100) % 2 == 0) ? 25 : 0;
            send_value(pick_value());
        end
    endtask

    task automatic test_steady_stream(input int unsigned count);
        idle_pct = 0;
        repeat (count) send_value(pick_value());
    endtask

    always @(posedge clk)
    begin
        if (rx_hold != 0)
        begin
            rx_hold  = rx_hold - 1;
            m_tready <= 1'b0;
        end
        else if (hold_request)
        begin
            rx_hold      = hold_len;
            hold_request = 1'b0;
            m_tready     <= 1'b0;
        end
        else if (rx_gap != 0)
        begin
            rx_gap   = rx_gap - 1;
            m_tready <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            rx_gap   = $urandom_range(1, 7) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        split_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_splits.size() == 0)
            begin
                $error("result word %h with nothing outstanding", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_splits.pop_front();
                if (m_tdata[15:0] !== want.root_factor)
                begin
                    $error("root_factor: expected %0d, actual %0d",
                           want.root_factor, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[46:16] !== want.square_free_part)
                begin
                    $error("square_free_part: expected %0d, actual %0d",
                           want.square_free_part, m_tdata[46:16]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_values();
        test_output_backpressure();
        test_pause_until_drained();
        test_mixed_random(400);
        test_steady_stream(150);
        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
